// ===== src/assert_macros.svh =====
// assertion macros shared by the clusterer rtl
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ODPM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ODPM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ODPM_ASSERT(lbl, clk, rstn, prop, msg)
`define ODPM_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== src/odpm_pkg.sv =====
// types, sizes and states of the online dp-means clusterer
// no dependencies
`timescale 1ns / 1ps
package odpm_pkg;

    localparam int DIM         = 16;
    localparam int MAX_CENTERS = 64;

    localparam int ELEM_W = 16;
    localparam int DIST_W = 36;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 6;

    localparam int DIM_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int POS_W  = $clog2(DIM + 1);
    localparam int CIDX_W = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int TOT_W  = $clog2(MAX_CENTERS + 1);
    localparam int ADDR_W = (MAX_CENTERS * DIM > 1) ? $clog2(MAX_CENTERS * DIM) : 1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    typedef struct packed {
        logic                     command;
        logic signed [ELEM_W-1:0] element;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  cluster_index;
        logic              created;
        logic              store_full;
        logic [DIST_W-1:0] distance_sq;
    } out_item_t;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              fin;
        logic              inlen;
        logic [CIDX_W-1:0] idx;
    } scan_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_NEW_RD,
        ST_NEW_WR,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_UPD_RD,
        ST_UPD_CALC,
        ST_UPD_DIV,
        ST_RESULT
    } state_t;

endpackage

// ===== src/odpm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
module odpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/odpm_div.sv =====
// restoring divider, one quotient bit per cycle, for center updates
// depends on odpm_pkg
`timescale 1ns / 1ps
module odpm_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [odpm_pkg::ELEM_W-1:0]     dividend,
    input  logic [odpm_pkg::CNT_W-1:0]      divisor,
    output logic                            done,
    output logic [odpm_pkg::ELEM_W-1:0]     quotient
);

    localparam int QW = odpm_pkg::ELEM_W;
    localparam int RW = odpm_pkg::CNT_W + 1;
    localparam int SW = $clog2(QW + 1);

    logic [SW-1:0]           step_reg, step_next;
    logic                    done_reg, done_next;
    logic [QW-1:0]           quo_reg, quo_next;
    logic [RW-1:0]           rem_reg, rem_next;
    logic [odpm_pkg::CNT_W-1:0] dvs_reg, dvs_next;
    logic [RW-1:0]           trial;

    always_comb begin
        step_next = step_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[RW-2:0], quo_reg[QW-1]};
        if (start) begin
            step_next = SW'(QW);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (step_reg != '0) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == SW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/odpm_dist.sv =====
// squared distance pipeline: square, accumulate with saturation, keep first minimum
// depends on odpm_pkg
`timescale 1ns / 1ps
module odpm_dist (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  odpm_pkg::scan_ctl_t               ctl,
    input  logic [odpm_pkg::ELEM_W-1:0]       z_word,
    input  logic [odpm_pkg::ELEM_W-1:0]       c_word,
    output logic                              done,
    output logic [odpm_pkg::CIDX_W-1:0]       best_idx,
    output logic [odpm_pkg::DIST_W-1:0]       best_dist
);

    localparam int EW = odpm_pkg::ELEM_W;
    localparam int DW = odpm_pkg::DIST_W;

    odpm_pkg::scan_ctl_t     ctl1_reg;
    logic [2*EW-1:0]         sq_reg;
    logic [DW-1:0]           acc_reg;
    logic [odpm_pkg::CIDX_W-1:0] best_idx_reg;
    logic [DW-1:0]           best_dist_reg;
    logic                    done_reg;

    logic signed [EW:0]      diff;
    logic [EW:0]             mag;
    logic [DW:0]             sum_wide;
    logic [DW-1:0]           sum;

    always_comb begin
        diff = $signed({z_word[EW-1], z_word}) - $signed({c_word[EW-1], c_word});
        mag  = diff[EW] ? (~diff + 1'b1) : diff;
        sum_wide = (ctl1_reg.first ? {(DW+1){1'b0}} : {1'b0, acc_reg})
                 + (DW+1)'(sq_reg);
        sum = sum_wide[DW] ? odpm_pkg::DIST_MAX : sum_wide[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= ctl;
            done_reg <= ctl1_reg.valid && ctl1_reg.fin;
        end
    end

    always_ff @(posedge aclk) begin
        sq_reg <= mag[EW-1:0] * mag[EW-1:0];
        if (ctl1_reg.valid) begin
            acc_reg <= sum;
            if (ctl1_reg.last && (ctl1_reg.idx == '0 || sum < best_dist_reg)) begin
                best_dist_reg <= sum;
                best_idx_reg  <= ctl1_reg.idx;
            end
        end
    end

    assign done      = done_reg;
    assign best_idx  = best_idx_reg;
    assign best_dist = best_dist_reg;

endmodule

// ===== src/online_dp_means_clusterer.sv =====
// Online DP-means clusterer. Elements arrive one item per cycle while idle into
// a vector buffer; the item with last set starts a scan that reads every stored
// center from the center memory, one element per cycle, through the distance
// pipeline and then a decision; a full store holds 64 centers of 16 elements.
// A learn update reads and writes the count, then for each element does a read,
// a divider start, 16 restoring-division steps and a write-back; opening a center
// does a read and a write per element. No input item is taken while a vector is
// being processed.
// depends on odpm_pkg, odpm_ram, odpm_dist, odpm_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module online_dp_means_clusterer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  odpm_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output odpm_pkg::out_item_t         m_data,
    input  logic                        radius_sq_wr_en,
    input  logic [odpm_pkg::DIST_W-1:0] radius_sq_wr_data
);

    localparam int EW = odpm_pkg::ELEM_W;
    localparam int DW = odpm_pkg::DIST_W;
    localparam int CW = odpm_pkg::CNT_W;
    localparam int XW = odpm_pkg::CIDX_W;
    localparam int TW = odpm_pkg::TOT_W;
    localparam int AW = odpm_pkg::ADDR_W;
    localparam int IW = odpm_pkg::DIM_W;
    localparam int PW = odpm_pkg::POS_W;

    odpm_pkg::state_t    state_reg, state_next;
    logic [PW-1:0]       pos_reg, pos_next, pos_inc;
    logic [PW-1:0]       len_reg, len_next;
    logic                cmd_reg, cmd_next;
    logic [TW-1:0]       total_reg, total_next;
    logic [IW-1:0]       i_reg, i_next;
    logic [XW-1:0]       c_reg, c_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [DW-1:0]       radius_reg;
    logic [XW-1:0]       best_idx_reg, best_idx_next;
    logic [DW-1:0]       best_dist_reg, best_dist_next;
    logic                created_reg, created_next;
    logic                full_reg, full_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [EW-1:0]       cur_reg, cur_next;
    logic                neg_reg, neg_next;
    odpm_pkg::scan_ctl_t ctl_reg, ctl_next;
    logic                m_valid_reg, m_valid_next;
    odpm_pkg::out_item_t m_data_reg, m_data_next;

    logic          vb_we;
    logic [IW-1:0] vb_waddr, vb_raddr;
    logic [EW-1:0] vb_rdata;
    logic          cr_we;
    logic [AW-1:0] cr_waddr, cr_raddr;
    logic [EW-1:0] cr_wdata, cr_rdata;
    logic          cn_we;
    logic [XW-1:0] cn_waddr, cn_raddr;
    logic [CW-1:0] cn_wdata, cn_rdata;

    logic          dist_done;
    logic [XW-1:0] dist_idx;
    logic [DW-1:0] dist_val;
    logic          div_start, div_done;
    logic [EW-1:0] div_mag, div_q;

    logic          dim_last, inlen;
    logic [EW-1:0] z_cur, z_scan;
    logic signed [EW:0] upd_diff;
    logic [EW:0]   upd_step;
    logic [EW:0]   upd_sum;
    logic [CW-1:0] n_inc;

    odpm_ram #(.WIDTH(EW), .DEPTH(odpm_pkg::DIM)) u_vbuf (
        .aclk(aclk), .we(vb_we), .waddr(vb_waddr), .wdata(s_data.element),
        .raddr(vb_raddr), .rdata(vb_rdata)
    );

    odpm_ram #(.WIDTH(EW), .DEPTH(odpm_pkg::MAX_CENTERS * odpm_pkg::DIM)) u_centers (
        .aclk(aclk), .we(cr_we), .waddr(cr_waddr), .wdata(cr_wdata),
        .raddr(cr_raddr), .rdata(cr_rdata)
    );

    odpm_ram #(.WIDTH(CW), .DEPTH(odpm_pkg::MAX_CENTERS)) u_counts (
        .aclk(aclk), .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
        .raddr(cn_raddr), .rdata(cn_rdata)
    );

    assign z_scan = ctl_reg.inlen ? vb_rdata : '0;

    odpm_dist u_dist (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl_reg), .z_word(z_scan),
        .c_word(cr_rdata), .done(dist_done), .best_idx(dist_idx), .best_dist(dist_val)
    );

    odpm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_mag),
        .divisor(n_reg), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        cmd_next       = cmd_reg;
        total_next     = total_reg;
        i_next         = i_reg;
        c_next         = c_reg;
        addr_next      = addr_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        created_next   = created_reg;
        full_next      = full_reg;
        n_next         = n_reg;
        cur_next       = cur_reg;
        neg_next       = neg_reg;
        ctl_next       = '0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        s_ready   = (state_reg == odpm_pkg::ST_IDLE);
        vb_we     = 1'b0;
        vb_waddr  = pos_reg[IW-1:0];
        vb_raddr  = i_reg;
        cr_we     = 1'b0;
        cr_waddr  = addr_reg;
        cr_wdata  = '0;
        cr_raddr  = addr_reg;
        cn_we     = 1'b0;
        cn_waddr  = best_idx_reg;
        cn_wdata  = CW'(1);
        cn_raddr  = best_idx_reg;
        div_start = 1'b0;

        dim_last = (i_reg == IW'(odpm_pkg::DIM - 1));
        inlen    = (PW'(i_reg) < len_reg);
        z_cur    = inlen ? vb_rdata : '0;
        pos_inc  = (pos_reg < PW'(odpm_pkg::DIM)) ? pos_reg + 1'b1 : pos_reg;
        upd_diff = $signed({z_cur[EW-1], z_cur}) - $signed({cr_rdata[EW-1], cr_rdata});
        div_mag  = upd_diff[EW] ? EW'(~upd_diff + 1'b1) : upd_diff[EW-1:0];
        upd_step = neg_reg ? (~{1'b0, div_q} + 1'b1) : {1'b0, div_q};
        upd_sum  = {cur_reg[EW-1], cur_reg} + upd_step;
        n_inc    = (cn_rdata == odpm_pkg::CNT_MAX) ? cn_rdata : cn_rdata + 1'b1;

        unique case (state_reg)
            odpm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    vb_we    = (pos_reg < PW'(odpm_pkg::DIM));
                    pos_next = pos_inc;
                    if (s_data.last) begin
                        len_next  = pos_inc;
                        pos_next  = '0;
                        cmd_next  = s_data.command;
                        i_next    = '0;
                        c_next    = '0;
                        addr_next = '0;
                        if (total_reg == '0) begin
                            best_idx_next  = '0;
                            best_dist_next = '0;
                            state_next     = odpm_pkg::ST_DECIDE;
                        end else begin
                            state_next = odpm_pkg::ST_SCAN;
                        end
                    end
                end
            end
            odpm_pkg::ST_SCAN: begin
                ctl_next.valid = 1'b1;
                ctl_next.first = (i_reg == '0);
                ctl_next.last  = dim_last;
                ctl_next.fin   = dim_last && (TW'(c_reg) + 1'b1 == total_reg);
                ctl_next.inlen = inlen;
                ctl_next.idx   = c_reg;
                addr_next      = addr_reg + 1'b1;
                if (dim_last) begin
                    i_next = '0;
                    c_next = c_reg + 1'b1;
                end else begin
                    i_next = i_reg + 1'b1;
                end
                if (ctl_next.fin) begin
                    state_next = odpm_pkg::ST_SCAN_WAIT;
                end
            end
            odpm_pkg::ST_SCAN_WAIT: begin
                if (dist_done) begin
                    best_idx_next  = dist_idx;
                    best_dist_next = dist_val;
                    state_next     = odpm_pkg::ST_DECIDE;
                end
            end
            odpm_pkg::ST_DECIDE: begin
                created_next = 1'b0;
                full_next    = 1'b0;
                i_next       = '0;
                if (cmd_reg) begin
                    state_next = odpm_pkg::ST_RESULT;
                end else if (total_reg == '0 || best_dist_reg > radius_reg) begin
                    if (total_reg < TW'(odpm_pkg::MAX_CENTERS)) begin
                        best_idx_next  = XW'(total_reg);
                        best_dist_next = '0;
                        created_next   = 1'b1;
                        addr_next      = AW'(32'(total_reg) * odpm_pkg::DIM);
                        state_next     = odpm_pkg::ST_NEW_RD;
                    end else begin
                        full_next  = 1'b1;
                        state_next = odpm_pkg::ST_RESULT;
                    end
                end else begin
                    addr_next  = AW'(32'(best_idx_reg) * odpm_pkg::DIM);
                    state_next = odpm_pkg::ST_CNT_RD;
                end
            end
            odpm_pkg::ST_NEW_RD: begin
                state_next = odpm_pkg::ST_NEW_WR;
            end
            odpm_pkg::ST_NEW_WR: begin
                cr_we     = 1'b1;
                cr_wdata  = z_cur;
                addr_next = addr_reg + 1'b1;
                if (dim_last) begin
                    cn_we      = 1'b1;
                    total_next = total_reg + 1'b1;
                    state_next = odpm_pkg::ST_RESULT;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = odpm_pkg::ST_NEW_RD;
                end
            end
            odpm_pkg::ST_CNT_RD: begin
                state_next = odpm_pkg::ST_CNT_WR;
            end
            odpm_pkg::ST_CNT_WR: begin
                cn_we      = 1'b1;
                cn_wdata   = n_inc;
                n_next     = n_inc;
                state_next = odpm_pkg::ST_UPD_RD;
            end
            odpm_pkg::ST_UPD_RD: begin
                state_next = odpm_pkg::ST_UPD_CALC;
            end
            odpm_pkg::ST_UPD_CALC: begin
                div_start  = 1'b1;
                cur_next   = cr_rdata;
                neg_next   = upd_diff[EW];
                state_next = odpm_pkg::ST_UPD_DIV;
            end
            odpm_pkg::ST_UPD_DIV: begin
                if (div_done) begin
                    cr_we     = 1'b1;
                    cr_wdata  = upd_sum[EW-1:0];
                    addr_next = addr_reg + 1'b1;
                    if (dim_last) begin
                        state_next = odpm_pkg::ST_RESULT;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = odpm_pkg::ST_UPD_RD;
                    end
                end
            end
            odpm_pkg::ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.cluster_index = odpm_pkg::IDX_W'(best_idx_reg);
                    m_data_next.created       = created_reg;
                    m_data_next.store_full    = full_reg;
                    m_data_next.distance_sq   = best_dist_reg;
                    state_next                = odpm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = odpm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= odpm_pkg::ST_IDLE;
            pos_reg     <= '0;
            total_reg   <= '0;
            radius_reg  <= '0;
            ctl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            ctl_reg     <= ctl_next;
            m_valid_reg <= m_valid_next;
            if (radius_sq_wr_en) begin
                radius_reg <= radius_sq_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg       <= len_next;
        cmd_reg       <= cmd_next;
        i_reg         <= i_next;
        c_reg         <= c_next;
        addr_reg      <= addr_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        created_reg   <= created_next;
        full_reg      <= full_next;
        n_reg         <= n_next;
        cur_reg       <= cur_next;
        neg_reg       <= neg_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ODPM_ASSERT_NEVER(a_total_range, aclk, aresetn, total_reg > TW'(odpm_pkg::MAX_CENTERS), "center count past store size")
    `ODPM_ASSERT_NEVER(a_pos_range, aclk, aresetn, pos_reg > PW'(odpm_pkg::DIM), "element position past vector size")
    `ODPM_ASSERT(a_dist_done_wait, aclk, aresetn, dist_done |-> state_reg == odpm_pkg::ST_SCAN_WAIT, "distance result outside scan wait")
    `ODPM_ASSERT(a_created_zero, aclk, aresetn, (m_valid_reg && m_data_reg.created) |-> (m_data_reg.distance_sq == '0 && !m_data_reg.store_full), "new center item with distance or full flag")

endmodule
